// File: rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at each rising clock edge, disabled while reset is high
`define RPBU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rpbu assertion failed");

// property checked at each rising clock edge, reset included
`define RPBU_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("rpbu assertion failed");

`endif

// File: rtl/rpbu_pkg.sv
// rgba pixel blend unit package: blend mode codes and channel arithmetic
// no dependencies
package rpbu_pkg;

   localparam int ChWidth   = 8;
   localparam int ModeWidth = 3;

   typedef logic [ChWidth-1:0]   ch_type;
   typedef logic [ModeWidth-1:0] mode_type;

   localparam ch_type ChMax = 8'hFF;
   localparam ch_type ChMin = 8'h00;

   localparam mode_type ModeAlpha    = 3'd0;
   localparam mode_type ModeReplace  = 3'd1;
   localparam mode_type ModeAdd      = 3'd2;
   localparam mode_type ModeSubtract = 3'd3;
   localparam mode_type ModeMultiply = 3'd4;
   localparam mode_type ModeLighten  = 3'd5;
   localparam mode_type ModeDarken   = 3'd6;
   localparam mode_type ModeScreen   = 3'd7;

   localparam mode_type ModeReset = ModeReplace;

   function automatic ch_type mul8(input ch_type a, input ch_type b);
      logic [2*ChWidth-1:0] p;
      begin
         p = {{ChWidth{1'b0}}, a} * {{ChWidth{1'b0}}, b};
         return p[2*ChWidth-1:ChWidth];
      end
   endfunction

   function automatic ch_type add_sat(input ch_type a, input ch_type b);
      logic [ChWidth:0] s;
      begin
         s = {1'b0, a} + {1'b0, b};
         return s[ChWidth] ? ChMax : s[ChWidth-1:0];
      end
   endfunction

   function automatic ch_type sub_clamp(input ch_type a, input ch_type b);
      begin
         return (a > b) ? ch_type'(a - b) : ChMin;
      end
   endfunction

   function automatic ch_type max8(input ch_type a, input ch_type b);
      begin
         return (a > b) ? a : b;
      end
   endfunction

   function automatic ch_type min8(input ch_type a, input ch_type b);
      begin
         return (a < b) ? a : b;
      end
   endfunction

endpackage

// File: rtl/rgba_pixel_blend_unit_top.sv
// rgba pixel blend unit top level: input register, blend logic, result register
// depends on rpbu_pkg
//
// usage:
//   request channel: drive the destination and source pixel on the req_ ports
//   and raise start; a request is taken at each rising edge with start high and
//   busy low. busy is always low, so one pixel can be taken every cycle.
//   result channel: rsp_valid is high for exactly one cycle with the blended
//   pixel on the rsp_ ports. the receiver cannot stall the block.
//   path: an accepted pixel passes one input register stage and then one
//   result register stage on its way to the rsp_ ports.
//   throughput: 1 pixel per cycle, set by the single pass of 8x8 multipliers,
//   one saturating add per channel and the mode select between the registers.
//   csr port: csr_write_enable writes csr_write_data into the blend mode
//   register; write it only while no request is in flight.
//   reset: synchronous, active high; clears the pipeline valid bits and sets
//   the blend mode to replace. requests in flight are dropped.
module rgba_pixel_blend_unit_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rpbu_pkg::ch_type       req_dst_red,
   input  rpbu_pkg::ch_type       req_dst_green,
   input  rpbu_pkg::ch_type       req_dst_blue,
   input  rpbu_pkg::ch_type       req_dst_alpha,
   input  rpbu_pkg::ch_type       req_src_red,
   input  rpbu_pkg::ch_type       req_src_green,
   input  rpbu_pkg::ch_type       req_src_blue,
   input  rpbu_pkg::ch_type       req_src_alpha,
   input  logic                   csr_write_enable,
   input  rpbu_pkg::mode_type     csr_write_data,
   output logic                   rsp_valid,
   output rpbu_pkg::ch_type       rsp_out_red,
   output rpbu_pkg::ch_type       rsp_out_green,
   output rpbu_pkg::ch_type       rsp_out_blue,
   output rpbu_pkg::ch_type       rsp_out_alpha
);
   import rpbu_pkg::*;

   mode_type mode_ff, mode_in;
   logic     req_valid_ff;
   ch_type   dst_ff [4];
   ch_type   src_ff [4];
   logic     rsp_valid_ff;
   ch_type   rsp_ff [4];
   ch_type   res_in [4];
   ch_type   sa;
   ch_type   inv_sa;

   assign busy = 1'b0;

   assign mode_in = csr_write_enable ? csr_write_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= ModeReset;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         req_valid_ff <= start & ~busy;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (start & ~busy) begin
         dst_ff[0] <= req_dst_red;
         dst_ff[1] <= req_dst_green;
         dst_ff[2] <= req_dst_blue;
         dst_ff[3] <= req_dst_alpha;
         src_ff[0] <= req_src_red;
         src_ff[1] <= req_src_green;
         src_ff[2] <= req_src_blue;
         src_ff[3] <= req_src_alpha;
      end
   end

   assign sa     = src_ff[3];
   assign inv_sa = ch_type'(ChMax - sa);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         case (mode_ff)
            ModeAlpha:
               res_in[i] = add_sat(mul8(dst_ff[i], inv_sa), mul8(src_ff[i], sa));
            ModeReplace:  res_in[i] = mul8(src_ff[i], sa);
            ModeAdd:      res_in[i] = add_sat(dst_ff[i], mul8(src_ff[i], sa));
            ModeSubtract: res_in[i] = sub_clamp(dst_ff[i], mul8(src_ff[i], sa));
            ModeMultiply: res_in[i] = mul8(src_ff[i], dst_ff[i]);
            ModeLighten:  res_in[i] = max8(src_ff[i], dst_ff[i]);
            ModeDarken:   res_in[i] = min8(src_ff[i], dst_ff[i]);
            default:
               res_in[i] = add_sat(mul8(dst_ff[i], ch_type'(ChMax - src_ff[i])),
                                   mul8(src_ff[i], sa));
         endcase
      end
      case (mode_ff)
         ModeAlpha:    res_in[3] = add_sat(mul8(dst_ff[3], inv_sa), sa);
         ModeReplace:  res_in[3] = sa;
         ModeAdd:      res_in[3] = dst_ff[3];
         ModeSubtract: res_in[3] = dst_ff[3];
         ModeMultiply: res_in[3] = mul8(sa, dst_ff[3]);
         ModeLighten:  res_in[3] = max8(sa, dst_ff[3]);
         ModeDarken:   res_in[3] = min8(sa, dst_ff[3]);
         default:      res_in[3] = add_sat(mul8(dst_ff[3], inv_sa), sa);
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_ff <= res_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_ff[0];
   assign rsp_out_green = rsp_ff[1];
   assign rsp_out_blue  = rsp_ff[2];
   assign rsp_out_alpha = rsp_ff[3];

endmodule

// File: rtl/rpbu_checker.sv
// port-level checker for the rgba pixel blend unit, bound to the top level
// depends on rpbu_pkg and assert_macros.svh
`include "assert_macros.svh"

module rpbu_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input rpbu_pkg::ch_type       req_dst_red,
   input rpbu_pkg::ch_type       req_dst_green,
   input rpbu_pkg::ch_type       req_dst_blue,
   input rpbu_pkg::ch_type       req_dst_alpha,
   input rpbu_pkg::ch_type       req_src_red,
   input rpbu_pkg::ch_type       req_src_green,
   input rpbu_pkg::ch_type       req_src_blue,
   input rpbu_pkg::ch_type       req_src_alpha,
   input logic                   csr_write_enable,
   input rpbu_pkg::mode_type     csr_write_data,
   input logic                   rsp_valid,
   input rpbu_pkg::ch_type       rsp_out_red,
   input rpbu_pkg::ch_type       rsp_out_green,
   input rpbu_pkg::ch_type       rsp_out_blue,
   input rpbu_pkg::ch_type       rsp_out_alpha
);
   import rpbu_pkg::*;

   // every accepted request gives a result
   `RPBU_ASSERT(a_req_to_rsp, clock, reset, (start && !busy) |-> ##2 rsp_valid)

   // no result without an earlier accepted request
   `RPBU_ASSERT(a_rsp_has_req, clock, reset, rsp_valid |-> $past(start && !busy, 2))

   // reset flushes the pipeline
   `RPBU_ASSERT_ALWAYS(a_reset_flush, clock, reset |=> !rsp_valid)

   // block never holds requests off
   `RPBU_ASSERT(a_never_busy, clock, reset, !busy)

endmodule

bind rgba_pixel_blend_unit_top rpbu_checker u_rpbu_checker (.*);

// File: dv/tb_rgba_pixel_blend_unit_top.sv
// testbench for rgba_pixel_blend_unit_top: blends pixels under every mode and checks each one
// against a predictor in this file; uses rpbu_pkg and the rtl top level only
module tb_rgba_pixel_blend_unit_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rpbu_pkg::*;

   typedef struct packed {
      ch_type red;
      ch_type green;
      ch_type blue;
      ch_type alpha;
   } rgba_t;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     start = 1'b0;
   logic     busy;
   ch_type   req_dst_red = '0;
   ch_type   req_dst_green = '0;
   ch_type   req_dst_blue = '0;
   ch_type   req_dst_alpha = '0;
   ch_type   req_src_red = '0;
   ch_type   req_src_green = '0;
   ch_type   req_src_blue = '0;
   ch_type   req_src_alpha = '0;
   logic     csr_write_enable = 1'b0;
   mode_type csr_write_data = ModeReset;
   logic     rsp_valid;
   ch_type   rsp_out_red;
   ch_type   rsp_out_green;
   ch_type   rsp_out_blue;
   ch_type   rsp_out_alpha;

   rgba_t    expected_pixels [$];
   mode_type blend_mode_now = ModeReset;
   int       error_count = 0;

   rgba_pixel_blend_unit_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_dst_red      (req_dst_red),
      .req_dst_green    (req_dst_green),
      .req_dst_blue     (req_dst_blue),
      .req_dst_alpha    (req_dst_alpha),
      .req_src_red      (req_src_red),
      .req_src_green    (req_src_green),
      .req_src_blue     (req_src_blue),
      .req_src_alpha    (req_src_alpha),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_out_alpha    (rsp_out_alpha)
   );

   always #5 clock = ~clock;

   function automatic int scale(input int x, input int y);
      return (x * y) >> 8;
   endfunction

   function automatic int clip(input int v);
      return (v > int'(ChMax)) ? int'(ChMax) : v;
   endfunction

   function automatic rgba_t blend_pixel(input mode_type mode, input rgba_t dst,
                                         input rgba_t src);
      int d [4];
      int s [4];
      int r [4];
      int full;
      int i;
      full = int'(ChMax);
      d[0] = dst.red;
      d[1] = dst.green;
      d[2] = dst.blue;
      d[3] = dst.alpha;
      s[0] = src.red;
      s[1] = src.green;
      s[2] = src.blue;
      s[3] = src.alpha;
      for (i = 0; i < 4; i++) r[i] = 0;
      case (mode)
         ModeAlpha: begin
            for (i = 0; i < 3; i++) r[i] = clip(scale(d[i], full - s[3]) + scale(s[i], s[3]));
            r[3] = clip(scale(d[3], full - s[3]) + s[3]);
         end
         ModeReplace: begin
            for (i = 0; i < 3; i++) r[i] = scale(s[i], s[3]);
            r[3] = s[3];
         end
         ModeAdd: begin
            for (i = 0; i < 3; i++) r[i] = clip(d[i] + scale(s[i], s[3]));
            r[3] = d[3];
         end
         ModeSubtract: begin
            for (i = 0; i < 3; i++) r[i] = (d[i] > scale(s[i], s[3])) ?
                                           d[i] - scale(s[i], s[3]) : int'(ChMin);
            r[3] = d[3];
         end
         ModeMultiply: begin
            for (i = 0; i < 4; i++) r[i] = scale(s[i], d[i]);
         end
         ModeLighten: begin
            for (i = 0; i < 4; i++) r[i] = (s[i] > d[i]) ? s[i] : d[i];
         end
         ModeDarken: begin
            for (i = 0; i < 4; i++) r[i] = (s[i] < d[i]) ? s[i] : d[i];
         end
         default: begin
            for (i = 0; i < 3; i++) r[i] = clip(scale(d[i], full - s[i]) + scale(s[i], s[3]));
            r[3] = clip(scale(d[3], full - s[3]) + s[3]);
         end
      endcase
      return {ch_type'(r[0]), ch_type'(r[1]), ch_type'(r[2]), ch_type'(r[3])};
   endfunction

   function automatic void check_channel(input string name, input ch_type want,
                                         input ch_type got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %02h actual %02h", $time, name, want, got);
      end
   endfunction

   // result checking and prediction of each accepted request
   always @(posedge clock) begin
      rgba_t got;
      rgba_t want;
      if (reset) begin
         blend_mode_now = ModeReset;
      end else begin
         if (rsp_valid) begin
            got = {rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha};
            if (expected_pixels.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none actual %08h", $time, got);
            end else begin
               want = expected_pixels.pop_front();
               check_channel("red", want.red, got.red);
               check_channel("green", want.green, got.green);
               check_channel("blue", want.blue, got.blue);
               check_channel("alpha", want.alpha, got.alpha);
            end
         end
         if (start && !busy) begin
            expected_pixels.push_back(blend_pixel(blend_mode_now,
               {req_dst_red, req_dst_green, req_dst_blue, req_dst_alpha},
               {req_src_red, req_src_green, req_src_blue, req_src_alpha}));
         end
         if (csr_write_enable) blend_mode_now = csr_write_data;
      end
   end

   task automatic send_pixel(input rgba_t dst, input rgba_t src);
      start <= 1'b1;
      req_dst_red <= dst.red;
      req_dst_green <= dst.green;
      req_dst_blue <= dst.blue;
      req_dst_alpha <= dst.alpha;
      req_src_red <= src.red;
      req_src_green <= src.green;
      req_src_blue <= src.blue;
      req_src_alpha <= src.alpha;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic wait_idle();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (expected_pixels.size() != 0 && guard < 100) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_blend_mode(input mode_type mode);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // opaque source on black, half alpha with saturation, subtract clamping below zero
   task automatic send_corner_pixels();
      send_pixel({ChMin, ChMin, ChMin, ChMin}, {ChMax, ChMax, ChMax, ChMax});
      send_pixel({ChMax, ChMax, ChMax, ChMax}, {ChMax, ChMax, ChMax, 8'h80});
      send_pixel({8'h10, 8'h10, 8'h10, 8'h10}, {8'hC0, 8'hC0, 8'hC0, ChMax});
   endtask

   function automatic ch_type random_channel();
      case ($urandom_range(9))
         0: return ChMin;
         1: return ChMax;
         default: return ch_type'($urandom);
      endcase
   endfunction

   function automatic rgba_t random_pixel();
      return {random_channel(), random_channel(), random_channel(), random_channel()};
   endfunction

   task automatic test_reset_mode();
      send_corner_pixels();
      wait_idle();
   endtask

   task automatic test_mode_extremes();
      int m;
      for (m = 0; m < 8; m++) begin
         write_blend_mode(mode_type'(m));
         send_corner_pixels();
      end
      wait_idle();
   endtask

   task automatic test_random_blends();
      int idle_pct [3];
      int p;
      int k;
      int n;
      int first;
      idle_pct = '{0, 48, 23};
      for (p = 0; p < 3; p++) begin
         first = $urandom_range(7);
         for (k = 0; k < 8; k++) begin
            write_blend_mode(mode_type'((first + k) % 8));
            for (n = 0; n < 75; n++) begin
               // every third stretch of 25 requests runs back to back
               if ((n / 25) % 3 != 2 && $urandom_range(99) < idle_pct[p]) begin
                  start <= 1'b0;
                  repeat ($urandom_range(1, 4)) @(posedge clock);
               end
               send_pixel(random_pixel(), random_pixel());
            end
         end
      end
      wait_idle();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_mode();
      test_mode_extremes();
      test_random_blends();
      wait_idle();
      if (expected_pixels.size() != 0) begin
         error_count++;
         $display("%0t: %0d results missing, expected %08h actual none", $time,
                  expected_pixels.size(), expected_pixels[0]);
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("%0t: timeout", $time);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/rpbu_pkg.sv
rtl/rgba_pixel_blend_unit_top.sv
rtl/rpbu_checker.sv
dv/tb_rgba_pixel_blend_unit_top.sv
